// ===== hw/rtl/rptw_pkg.sv =====
// ============================================================================
// rptw_pkg
// Shared types, constants and helpers of the radix page table walker.
// ============================================================================
package rptw_pkg;

    // Table geometry
    localparam int FRAMES     = 256;
    localparam int LEVELS     = 5;
    localparam int INDEX_BITS = 9;

    // Fixed field widths
    localparam int OP_BITS        = 2;
    localparam int VPAGE_BITS     = 45;
    localparam int PPAGE_BITS     = 52;
    localparam int CFG_BITS       = 8;
    localparam int CFG_INDEX_BITS = 2;

    // Derived widths
    localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NF_BITS    = $clog2(FRAMES + 1);
    localparam int LEVEL_BITS = $clog2(LEVELS + 1);
    localparam int ADDR_BITS  = FRAME_BITS + INDEX_BITS;
    localparam int ENTRY_BITS = PPAGE_BITS + 1;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_BITS-1:0] OP_MAP   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_UNMAP = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROOT_FRAME = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ALLOC_BASE = 2'd1;

    // Register reset values
    localparam logic [CFG_BITS-1:0] ROOT_FRAME_RESET = 8'd0;
    localparam logic [CFG_BITS-1:0] ALLOC_BASE_RESET = 8'd1;

    // Request beat
    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [VPAGE_BITS-1:0] virtual_page;
        logic [PPAGE_BITS-1:0] physical_page;
    } rptw_req_t;

    // Response beat
    typedef struct packed {
        logic                  mapped;
        logic [PPAGE_BITS-1:0] result_page;
        logic                  out_of_frames;
    } rptw_rsp_t;

    // Frame flag updates: set marks a frame as logically empty,
    // clear marks it as physically cleared and in use
    typedef struct packed {
        logic                  set_en;
        logic [FRAME_BITS-1:0] set_frame;
        logic                  clr_en;
        logic [FRAME_BITS-1:0] clr_frame;
    } rptw_flag_cmd_t;

    // Allocator reload from the register port
    typedef struct packed {
        logic                load;
        logic [CFG_BITS-1:0] base;
    } rptw_alloc_cfg_t;

    // Table index of one level (level 1 = leaf table, lowest bits)
    function automatic logic [INDEX_BITS-1:0] slot_index(
        input logic [VPAGE_BITS-1:0] vp,
        input logic [LEVEL_BITS-1:0] level
    );
        logic [INDEX_BITS-1:0] idx;
        idx = '0;
        for (int l = 1; l <= LEVELS; l++) begin
            if (level == LEVEL_BITS'(l))
            begin
                idx = vp[(l-1)*INDEX_BITS +: INDEX_BITS];
            end
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/radix_page_table_walker_core.sv =====
// ============================================================================
// radix_page_table_walker_core
// Five-level radix page table walker over an internal frame memory.
// ============================================================================
//
//  Channel   Signals                          Beat taken when
//  -------   -------------------------------  -----------------------------
//  request   start, busy, req                 start high and busy low
//  response  done, rsp                        done high (one cycle only)
//  config    cfg_wr_en, cfg_index, cfg_data   cfg_wr_en high
//
//  One request at a time; busy stays high from acceptance until the cycle
//  after the done beat. A query reads and evaluates one entry per table
//  level (a RAM read state, then an evaluation state). Map and unmap walk
//  as far as valid entries reach, then decide what to write; map passes
//  each entry it writes through an allocation and a write state. A frame
//  first written after allocation or reset is swept first (512 single-entry
//  clears, one RAM write per cycle, then the held entry write). Reset takes
//  effect at once: per-frame flags mark the whole store empty, so no clearing
//  pass runs. The receiver cannot stall; done is a one-cycle strobe.
//
// ============================================================================
module radix_page_table_walker_core
    import rptw_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  rptw_req_t                 req,
    output logic                      done,
    output rptw_rsp_t                 rsp,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    logic [CFG_BITS-1:0]   root_frame_reg;
    logic [CFG_BITS-1:0]   root_frame_next;
    rptw_alloc_cfg_t       alloc_cfg;

    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_BITS-1:0]  ram_addr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [ENTRY_BITS-1:0] ram_rdata;

    logic [FRAME_BITS-1:0] flag_frame;
    rptw_flag_cmd_t        flag_cmd;
    logic                  flag_zero;

    // Register decode
    always_comb
    begin
        root_frame_next = root_frame_reg;
        alloc_cfg.load  = 1'b0;
        alloc_cfg.base  = cfg_data;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ROOT_FRAME: root_frame_next = cfg_data;
                CFG_ALLOC_BASE: alloc_cfg.load  = 1'b1;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_frame_reg <= ROOT_FRAME_RESET;
        end
        else
        begin
            root_frame_reg <= root_frame_next;
        end
    end

    // Walk sequencer
    rptw_walk_fsm u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .busy       (busy),
        .done       (done),
        .rsp        (rsp),
        .root_frame (root_frame_reg),
        .alloc_cfg  (alloc_cfg),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata),
        .flag_frame (flag_frame),
        .flag_cmd   (flag_cmd),
        .flag_zero  (flag_zero)
    );

    // Frame store
    rptw_frame_ram #(
        .ADDR_W (ADDR_BITS),
        .DATA_W (ENTRY_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Per-frame empty flags
    rptw_frame_flags u_flags (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (flag_cmd),
        .frame (flag_frame),
        .zero  (flag_zero)
    );

endmodule

// ===== hw/rtl/rptw_frame_ram.sv =====
// ============================================================================
// rptw_frame_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ============================================================================
module rptw_frame_ram #(
    parameter int ADDR_W = 17,
    parameter int DATA_W = 53
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== hw/rtl/rptw_frame_flags.sv =====
// ============================================================================
// rptw_frame_flags
// One flag per frame: set means the frame reads as all-invalid and its
// memory contents are stale until swept.
// ============================================================================
module rptw_frame_flags
    import rptw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rptw_flag_cmd_t        cmd,
    input  logic [FRAME_BITS-1:0] frame,
    output logic                  zero
);

    logic [FRAMES-1:0] zero_reg;
    logic [FRAMES-1:0] zero_next;

    // Set on allocation, clear after the sweep
    always_comb
    begin
        zero_next = zero_reg;
        if (cmd.set_en)
        begin
            zero_next[cmd.set_frame] = 1'b1;
        end
        if (cmd.clr_en)
        begin
            zero_next[cmd.clr_frame] = 1'b0;
        end
    end

    // Every frame is logically empty after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= '1;
        end
        else
        begin
            zero_reg <= zero_next;
        end
    end

    assign zero = zero_reg[frame];

endmodule

// ===== hw/rtl/rptw_walk_fsm.sv =====
// ============================================================================
// rptw_walk_fsm
// Walk sequencer: reads the path, allocates frames, sweeps fresh frames and
// writes entries back; holds the frame allocator.
// ============================================================================
module rptw_walk_fsm
    import rptw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rptw_req_t             req,
    output logic                  busy,
    output logic                  done,
    output rptw_rsp_t             rsp,
    input  logic [CFG_BITS-1:0]   root_frame,
    input  rptw_alloc_cfg_t       alloc_cfg,
    output logic                  ram_we,
    output logic                  ram_re,
    output logic [ADDR_BITS-1:0]  ram_addr,
    output logic [ENTRY_BITS-1:0] ram_wdata,
    input  logic [ENTRY_BITS-1:0] ram_rdata,
    output logic [FRAME_BITS-1:0] flag_frame,
    output rptw_flag_cmd_t        flag_cmd,
    input  logic                  flag_zero
);

    localparam int SUM_BITS = ((NF_BITS > LEVEL_BITS) ? NF_BITS : LEVEL_BITS) + 1;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_READ   = 8'b0000_0010,
        S_EVAL   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_ALLOC  = 8'b0001_0000,
        S_WRITE  = 8'b0010_0000,
        S_SWEEP  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OP_BITS-1:0]      op_reg, op_next;
    logic [VPAGE_BITS-1:0]   vp_reg, vp_next;
    logic [PPAGE_BITS-1:0]   pp_reg, pp_next;
    logic [FRAME_BITS-1:0]   frame_reg, frame_next;
    logic [FRAME_BITS-1:0]   child_reg, child_next;
    logic [LEVEL_BITS-1:0]   level_reg, level_next;
    logic [ENTRY_BITS-1:0]   wdata_reg, wdata_next;
    logic                    zflag_reg, zflag_next;
    logic [INDEX_BITS-1:0]   sweep_reg, sweep_next;
    logic [NF_BITS-1:0]      next_free_reg, next_free_next;
    logic                    mapped_reg, mapped_next;
    logic [PPAGE_BITS-1:0]   page_reg, page_next;
    logic                    oof_reg, oof_next;

    logic [INDEX_BITS-1:0]   idx;
    logic [ENTRY_BITS-1:0]   entry;
    logic                    entry_usable;
    logic                    op_known;
    logic                    root_ok;
    logic [SUM_BITS-1:0]     need_sum;

    // Entry as seen by the walk: an empty frame reads as zero
    assign idx          = slot_index(vp_reg, level_reg);
    assign entry        = zflag_reg ? '0 : ram_rdata;
    assign entry_usable = entry[PPAGE_BITS]
                       && (entry[PPAGE_BITS-1:0] < PPAGE_BITS'(FRAMES));
    assign op_known     = (req.operation == OP_QUERY) || (req.operation == OP_MAP)
                       || (req.operation == OP_UNMAP);
    assign root_ok      = (32'(root_frame) < FRAMES);
    assign need_sum     = SUM_BITS'(next_free_reg) + SUM_BITS'(level_reg) - SUM_BITS'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        vp_next        = vp_reg;
        pp_next        = pp_reg;
        frame_next     = frame_reg;
        child_next     = child_reg;
        level_next     = level_reg;
        wdata_next     = wdata_reg;
        zflag_next     = zflag_reg;
        sweep_next     = sweep_reg;
        next_free_next = next_free_reg;
        mapped_next    = mapped_reg;
        page_next      = page_reg;
        oof_next       = oof_reg;

        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = {frame_reg, idx};
        ram_wdata = wdata_reg;
        flag_cmd  = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = req.operation;
                    vp_next     = req.virtual_page;
                    pp_next     = req.physical_page;
                    frame_next  = FRAME_BITS'(root_frame);
                    level_next  = LEVEL_BITS'(LEVELS);
                    mapped_next = 1'b0;
                    page_next   = '0;
                    oof_next    = 1'b0;
                    if (op_known && root_ok)
                    begin
                        if ((LEVELS > 1) || (req.operation == OP_QUERY))
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                zflag_next = flag_zero;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (level_reg == LEVEL_BITS'(1))
                begin
                    // leaf of a query
                    mapped_next = entry[PPAGE_BITS];
                    page_next   = entry[PPAGE_BITS] ? entry[PPAGE_BITS-1:0] : '0;
                    state_next  = S_DONE;
                end
                else if (entry_usable)
                begin
                    frame_next = FRAME_BITS'(entry[PPAGE_BITS-1:0]);
                    level_next = level_reg - LEVEL_BITS'(1);
                    if ((level_reg > LEVEL_BITS'(2)) || (op_reg == OP_QUERY))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_DECIDE;
                    end
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_DONE;
                if (op_reg == OP_UNMAP)
                begin
                    if (level_reg == LEVEL_BITS'(1))
                    begin
                        wdata_next = '0;
                        state_next = S_WRITE;
                    end
                end
                else if (op_reg == OP_MAP)
                begin
                    // one fresh frame per missing level
                    if (need_sum > SUM_BITS'(FRAMES))
                    begin
                        oof_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ALLOC;
                    end
                end
            end

            S_ALLOC:
            begin
                if (level_reg > LEVEL_BITS'(1))
                begin
                    child_next         = FRAME_BITS'(next_free_reg);
                    next_free_next     = next_free_reg + NF_BITS'(1);
                    flag_cmd.set_en    = 1'b1;
                    flag_cmd.set_frame = FRAME_BITS'(next_free_reg);
                    wdata_next         = {1'b1, PPAGE_BITS'(next_free_reg)};
                end
                else
                begin
                    wdata_next = {1'b1, pp_reg};
                end
                state_next = S_WRITE;
            end

            S_WRITE:
            begin
                if (flag_zero)
                begin
                    // stale frame: clear it before the first write
                    sweep_next = '0;
                    state_next = S_SWEEP;
                end
                else
                begin
                    ram_we = 1'b1;
                    if ((op_reg == OP_MAP) && (level_reg > LEVEL_BITS'(1)))
                    begin
                        frame_next = child_reg;
                        level_next = level_reg - LEVEL_BITS'(1);
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SWEEP:
            begin
                ram_we     = 1'b1;
                ram_addr   = {frame_reg, sweep_reg};
                ram_wdata  = '0;
                sweep_next = sweep_reg + INDEX_BITS'(1);
                if (sweep_reg == '1)
                begin
                    flag_cmd.clr_en    = 1'b1;
                    flag_cmd.clr_frame = frame_reg;
                    state_next         = S_WRITE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Allocator reload from the register port
        if (alloc_cfg.load)
        begin
            next_free_next = NF_BITS'(alloc_cfg.base);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_free_reg <= NF_BITS'(ALLOC_BASE_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        vp_reg     <= vp_next;
        pp_reg     <= pp_next;
        frame_reg  <= frame_next;
        child_reg  <= child_next;
        level_reg  <= level_next;
        wdata_reg  <= wdata_next;
        zflag_reg  <= zflag_next;
        sweep_reg  <= sweep_next;
        mapped_reg <= mapped_next;
        page_reg   <= page_next;
        oof_reg    <= oof_next;
    end

    assign flag_frame        = frame_reg;
    assign busy              = (state_reg != S_IDLE);
    assign done              = (state_reg == S_DONE);
    assign rsp.mapped        = mapped_reg;
    assign rsp.result_page   = page_reg;
    assign rsp.out_of_frames = oof_reg;

endmodule

// ===== verif/radix_page_table_walker_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// radix_page_table_walker_core_tb
// Self-checking bench for the five-level page table walker. A short table of
// directed requests and register writes runs first: empty tables, extreme
// pages, unused opcode, stale pointers, allocator exhaustion. Random phases
// follow, each with fresh root/allocator settings and a small pool of related
// virtual pages so that walks share prefixes and queries hit. Every response
// beat is checked against a local model of frame store and allocator, or a fixed want.
// ============================================================================
module radix_page_table_walker_core_tb;
    import rptw_pkg::*;

    localparam int ENTRIES         = 1 << INDEX_BITS;
    localparam int PHASES          = 14;
    localparam int ITEMS_PER_PHASE = 124;
    localparam int POOL_SIZE       = 12;
    localparam int TAIL_CYCLES     = 24;
    // worst map sweeps five frames of 512 entries each; leave a wide margin
    localparam int WATCHDOG_LIMIT  = 20000;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] reg_idx;
        logic [CFG_BITS-1:0]       reg_val;
        rptw_req_t                 beat;
        logic                      fixed;
        rptw_rsp_t                 want;
    } plan_row_t;

    // DUT signals
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    rptw_req_t                 req = '0;
    logic                      done;
    rptw_rsp_t                 rsp;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]       cfg_data = '0;

    // Local model of the block
    bit [ENTRY_BITS-1:0] pte_mem [FRAMES * ENTRIES];
    int                  root_reg  = int'(ROOT_FRAME_RESET);
    int                  alloc_ptr = int'(ALLOC_BASE_RESET);

    rptw_rsp_t pending_rsp[$];
    rptw_rsp_t head_rsp;
    plan_row_t plan[$];

    int errors = 0;
    int n_checked = 0;
    int n_query = 0, n_hit = 0, n_map = 0, n_oof = 0, n_unmap = 0, n_unused = 0;
    int n_writes = 0;
    int burst_left = 0;
    int stall_cycles = 0;

    radix_page_table_walker_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic int entry_addr(input int frame, input logic [VPAGE_BITS-1:0] vp,
                                      input int level);
        return frame * ENTRIES + int'(vp[(level-1)*INDEX_BITS +: INDEX_BITS]);
    endfunction

    // Applies one request to the model, returns the response it must produce
    function automatic rptw_rsp_t walk_predict(input rptw_req_t r);
        int                  level;
        int                  frame;
        int                  nf;
        bit [ENTRY_BITS-1:0] e;
        rptw_rsp_t           res;
        res = '0;
        if (r.operation == OP_UNUSED || root_reg >= FRAMES)
        begin
            if (r.operation == OP_UNUSED)
                n_unused++;
            return res;
        end
        // descend while interior entries are valid and inside the store
        level = LEVELS;
        frame = root_reg;
        while (level > 1)
        begin
            e = pte_mem[entry_addr(frame, r.virtual_page, level)];
            if (!e[PPAGE_BITS] || e[PPAGE_BITS-1:0] >= FRAMES)
                break;
            frame = int'(e[FRAME_BITS-1:0]);
            level--;
        end
        if (r.operation == OP_QUERY)
        begin
            n_query++;
            if (level == 1)
            begin
                e = pte_mem[entry_addr(frame, r.virtual_page, 1)];
                if (e[PPAGE_BITS])
                begin
                    res.mapped      = 1'b1;
                    res.result_page = e[PPAGE_BITS-1:0];
                    n_hit++;
                end
            end
        end
        else if (r.operation == OP_UNMAP)
        begin
            n_unmap++;
            if (level == 1)
                pte_mem[entry_addr(frame, r.virtual_page, 1)] = '0;
        end
        else
        begin
            n_map++;
            if (level - 1 > FRAMES - alloc_ptr)
            begin
                res.out_of_frames = 1'b1;
                n_oof++;
            end
            else
            begin
                // fresh frames are cleared before the link is written
                while (level > 1)
                begin
                    nf = alloc_ptr;
                    alloc_ptr++;
                    for (int i = 0; i < ENTRIES; i++)
                        pte_mem[nf * ENTRIES + i] = '0;
                    pte_mem[entry_addr(frame, r.virtual_page, level)] =
                        {1'b1, PPAGE_BITS'(nf)};
                    frame = nf;
                    level--;
                end
                pte_mem[entry_addr(frame, r.virtual_page, 1)] = {1'b1, r.physical_page};
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic plan_row_t op_row(input logic [OP_BITS-1:0] op,
                                         input logic [VPAGE_BITS-1:0] vp,
                                         input logic [PPAGE_BITS-1:0] pp);
        plan_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.beat = '{operation: op, virtual_page: vp, physical_page: pp};
        return row;
    endfunction

    function automatic plan_row_t lit_row(input logic [OP_BITS-1:0] op,
                                          input logic [VPAGE_BITS-1:0] vp,
                                          input logic [PPAGE_BITS-1:0] pp,
                                          input logic hit,
                                          input logic [PPAGE_BITS-1:0] page,
                                          input logic oof);
        plan_row_t row;
        row = op_row(op, vp, pp);
        row.fixed = 1'b1;
        row.want = '{mapped: hit, result_page: page, out_of_frames: oof};
        return row;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_INDEX_BITS-1:0] idx,
                                          input logic [CFG_BITS-1:0] val);
        plan_row_t row;
        row = '0;
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    // table index: mostly random, sometimes the first or last entry
    function automatic logic [INDEX_BITS-1:0] pick_index();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return INDEX_BITS'($urandom);
    endfunction

    // page that shares the upper path with base; upper levels change rarely
    function automatic logic [VPAGE_BITS-1:0] vpage_near(input logic [VPAGE_BITS-1:0] base);
        logic [VPAGE_BITS-1:0] v;
        v = base;
        v[0 +: INDEX_BITS] = pick_index();
        if ($urandom_range(0, 2) == 0)
            v[INDEX_BITS +: INDEX_BITS] = pick_index();
        if ($urandom_range(0, 5) == 0)
            v[2*INDEX_BITS +: INDEX_BITS] = pick_index();
        if ($urandom_range(0, 9) == 0)
            v[3*INDEX_BITS +: INDEX_BITS] = pick_index();
        if ($urandom_range(0, 15) == 0)
            v[4*INDEX_BITS +: INDEX_BITS] = pick_index();
        return v;
    endfunction

    // Holds start until the beat is taken, then queues the expected response
    task automatic send_req(input rptw_req_t r, input logic fixed, input rptw_rsp_t want);
        rptw_rsp_t model_rsp;
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        model_rsp = walk_predict(r);
        pending_rsp.push_back(fixed ? want : model_rsp);
    endtask

    // Bursts of back-to-back requests separated by random gaps
    task automatic pace();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // Stop sending until every response is in and the block is idle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ROOT_FRAME)
            root_reg = int'(val);
        else if (idx == CFG_ALLOC_BASE)
            alloc_ptr = int'(val);
        n_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Response checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response beat with none pending: %p", $time, rsp);
                errors++;
            end
            else
            begin
                head_rsp = pending_rsp.pop_front();
                n_checked++;
                if (rsp.mapped !== head_rsp.mapped)
                begin
                    $display("%0t: mapped exp %b got %b", $time, head_rsp.mapped, rsp.mapped);
                    errors++;
                end
                if (rsp.result_page !== head_rsp.result_page)
                begin
                    $display("%0t: result_page exp %h got %h", $time,
                             head_rsp.result_page, rsp.result_page);
                    errors++;
                end
                if (rsp.out_of_frames !== head_rsp.out_of_frames)
                begin
                    $display("%0t: out_of_frames exp %b got %b", $time,
                             head_rsp.out_of_frames, rsp.out_of_frames);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with no request or response beat
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [VPAGE_BITS-1:0] pool [POOL_SIZE];
        logic [VPAGE_BITS-1:0] base_vp;
        rptw_req_t             beat;
        int                    r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Frames 1..4 back page 0, frames 5..8 the top page.
        plan.push_back(lit_row(OP_QUERY, '0, '0, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_QUERY, '1, '0, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_MAP, '0, '1, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_QUERY, '0, '0, 1'b1, '1, 1'b0));
        plan.push_back(lit_row(OP_MAP, '1, '0, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_QUERY, '1, '0, 1'b1, '0, 1'b0));
        plan.push_back(lit_row(OP_UNMAP, '1, '0, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_QUERY, '1, '0, 1'b0, '0, 1'b0));
        // unmap on a path that was never built
        plan.push_back(lit_row(OP_UNMAP, 45'h0010_0000_0000, '0, 1'b0, '0, 1'b0));
        // unused opcode must leave page 0 alone
        plan.push_back(lit_row(OP_UNUSED, '0, '1, 1'b0, '0, 1'b0));
        plan.push_back(lit_row(OP_QUERY, '0, '0, 1'b1, '1, 1'b0));
        plan.push_back(op_row(OP_MAP, 45'h0AAA_AAAA_AAAA, 52'h5_5555_5555_5555));
        plan.push_back(op_row(OP_QUERY, 45'h0AAA_AAAA_AAAA, '0));
        plan.push_back(op_row(OP_MAP, 45'd1, 52'd3));
        // leaf table of page 0 as root: its entries become stale or out-of-store pointers
        plan.push_back(reg_row(CFG_ROOT_FRAME, 8'd4));
        plan.push_back(op_row(OP_QUERY, '0, '0));
        plan.push_back(op_row(OP_UNMAP, '0, '0));
        plan.push_back(op_row(OP_MAP, '0, 52'h12));
        // three frames left, a new path needs four
        plan.push_back(reg_row(CFG_ROOT_FRAME, 8'd200));
        plan.push_back(reg_row(CFG_ALLOC_BASE, 8'd253));
        plan.push_back(lit_row(OP_MAP, 45'h1234_5678_9ABC, 52'hABC, 1'b0, '0, 1'b1));
        plan.push_back(lit_row(OP_QUERY, 45'h1234_5678_9ABC, '0, 1'b0, '0, 1'b0));
        plan.push_back(reg_row(CFG_ALLOC_BASE, 8'd252));
        plan.push_back(op_row(OP_MAP, 45'h1234_5678_9ABC, 52'hABC));
        // last frame: a sibling leaf needs none, a new top entry needs four
        plan.push_back(reg_row(CFG_ALLOC_BASE, 8'd255));
        plan.push_back(op_row(OP_MAP, 45'h1234_5678_9A00, '0));
        plan.push_back(lit_row(OP_MAP, '0, 52'h77, 1'b0, '0, 1'b1));
        // extremes of both registers; allocator restarts over frame 0
        plan.push_back(reg_row(CFG_ROOT_FRAME, 8'd255));
        plan.push_back(reg_row(CFG_ALLOC_BASE, 8'd0));
        plan.push_back(op_row(OP_MAP, '1, '1));
        plan.push_back(lit_row(OP_QUERY, '1, '0, 1'b1, '1, 1'b0));
        plan.push_back(op_row(OP_QUERY, '0, '0));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                pace();
                send_req(plan[i].beat, plan[i].fixed, plan[i].want);
            end
        end

        // Random phases: new settings, then traffic around a pool of related pages
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_ROOT_FRAME, CFG_BITS'($urandom_range(0, 31)));
            else
                write_reg(CFG_ROOT_FRAME, CFG_BITS'($urandom_range(128, 255)));
            if ($urandom_range(0, 4) == 0)
                write_reg(CFG_ALLOC_BASE, CFG_BITS'($urandom_range(236, 255)));
            else
                write_reg(CFG_ALLOC_BASE, CFG_BITS'($urandom_range(0, 96)));

            base_vp = VPAGE_BITS'({$urandom, $urandom});
            foreach (pool[k])
                pool[k] = vpage_near(base_vp);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    beat.operation = OP_MAP;
                else if (r < 85)
                    beat.operation = OP_QUERY;
                else if (r < 95)
                    beat.operation = OP_UNMAP;
                else
                    beat.operation = OP_UNUSED;

                r = $urandom_range(0, 19);
                if (r == 0)
                    beat.virtual_page = VPAGE_BITS'({$urandom, $urandom});
                else if (r == 1)
                    beat.virtual_page = vpage_near(pool[$urandom_range(0, POOL_SIZE-1)]);
                else
                    beat.virtual_page = pool[$urandom_range(0, POOL_SIZE-1)];

                // small leaf values double as frame pointers when the root moves
                case ($urandom_range(0, 5)) inside
                    0: beat.physical_page = '0;
                    1: beat.physical_page = '1;
                    [2:3]: beat.physical_page = PPAGE_BITS'($urandom_range(0, FRAMES-1));
                    default: beat.physical_page = PPAGE_BITS'({$urandom, $urandom});
                endcase

                if (n == ITEMS_PER_PHASE / 2)
                    drain();
                else
                    pace();
                send_req(beat, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d queries (%0d hits), %0d maps (%0d out of frames), %0d unmaps,",
                 n_query, n_hit, n_map, n_oof, n_unmap);
        $display("%0d unused opcodes, %0d register writes; %0d responses checked, %0d errors",
                 n_unused, n_writes, n_checked, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
